@@ rtl/bson_element_stream_parser_defines.svh @@
// ----------------------------------------------------------------------------
// bson element stream parser assertion macros
// shared assertion forms for the parser checker
// ----------------------------------------------------------------------------
`ifndef BSON_ELEMENT_STREAM_PARSER_DEFINES_SVH
`define BSON_ELEMENT_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BSEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsep check failed");

// next-cycle implication, disabled while reset is low
`define BSEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsep check failed");

`endif

@@ rtl/bsep_pkg.sv @@
// ----------------------------------------------------------------------------
// bsep_pkg
// shared codes and types of the bson element stream parser
// ----------------------------------------------------------------------------
package bsep_pkg;

    // parser phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HEADER  = 4'd1;
    localparam logic [3:0] PH_TYPE    = 4'd2;
    localparam logic [3:0] PH_NAME    = 4'd3;
    localparam logic [3:0] PH_FIXED   = 4'd4;
    localparam logic [3:0] PH_LENWORD = 4'd5;
    localparam logic [3:0] PH_BODY    = 4'd6;

    // result status codes
    localparam logic [1:0] ST_ELEM = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    // element type codes
    localparam logic [7:0] T_FP64      = 8'h01;
    localparam logic [7:0] T_STRING    = 8'h02;
    localparam logic [7:0] T_DOCUMENT  = 8'h03;
    localparam logic [7:0] T_ARRAY     = 8'h04;
    localparam logic [7:0] T_BINARY    = 8'h05;
    localparam logic [7:0] T_UNDEFINED = 8'h06;
    localparam logic [7:0] T_BOOLEAN   = 8'h08;
    localparam logic [7:0] T_NULL      = 8'h0A;
    localparam logic [7:0] T_INT32     = 8'h10;
    localparam logic [7:0] T_INT64     = 8'h12;

    // decoded fixed-size payload
    typedef struct packed {
        logic [63:0] raw_value;
        logic        is_truthy;
        logic [3:0]  data_length;
    } t_fixed_val;

endpackage

@@ rtl/bson_element_stream_parser.sv @@
// ----------------------------------------------------------------------------
// bson_element_stream_parser
// byte-serial bson document walker with one result per element
// ----------------------------------------------------------------------------
// The parser takes one document byte per beat and sustains one beat per
// cycle while the output is not stalled; the result of a byte passes
// through the input register, then the result register. The first byte
// of a document is flagged with i_first, which restarts the parser at any
// point. The first four bytes give the little-endian total length, checked
// against the buffer length register. Each element then yields an element
// result (status 0) with its type, offsets, lengths, raw value and
// truthiness; a zero type byte ends the document (status 1); any violation
// gives a failure result (status 2) carrying the failing element's start
// offset and type. After an end or failure, bytes are dropped until the next
// flagged first byte. The buffer length register is written through the
// cfg channel, which is always ready, and should only change while idle.
// ----------------------------------------------------------------------------
module bson_element_stream_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [30:0]        i_buffer_length,
    // byte input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [7:0]         o_elem_type,
    output logic [30:0]        o_elem_offset,
    output logic [30:0]        o_name_length,
    output logic [30:0]        o_data_offset,
    output logic [30:0]        o_data_length,
    output logic signed [63:0] o_raw_value,
    output logic               o_is_truthy
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  elem_type;
        logic [30:0] elem_offset;
        logic [30:0] name_length;
        logic [30:0] data_offset;
        logic [30:0] data_length;
        logic [63:0] raw_value;
        logic        is_truthy;
    } t_result;

    // configuration register
    logic [30:0] r_buffer_length;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;

    // parser state
    logic [3:0]  r_phase,      n_phase;
    logic [30:0] r_position,   n_position;
    logic [31:0] r_doc_total,  n_doc_total;
    logic [7:0]  r_cur_type,   n_cur_type;
    logic [30:0] r_elem_start, n_elem_start;
    logic [30:0] r_data_start, n_data_start;
    logic [31:0] r_length_word, n_length_word;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [63:0] r_value,      n_value;

    // result register
    logic        r_out_valid;
    t_result     r_out;

    // step logic
    logic        out_free;
    logic        proc_go;
    logic        res_valid;
    t_result     res;
    logic [3:0]  cur_phase;
    logic [30:0] cur_pos;
    logic [31:0] cur_total;
    logic [31:0] hdr_total;
    logic        pos_past;
    logic [63:0] shifted;
    logic        left_done;
    logic [3:0]  fixed_n;
    logic [33:0] ds_end;
    logic [31:0] lw;
    logic [32:0] body;
    logic [33:0] body_end;
    logic        lw_bad;
    logic        acc;
    logic [30:0] acc_dlen;
    logic [63:0] acc_raw;
    logic        acc_truthy;
    bsep_pkg::t_fixed_val fixed;

    function automatic t_result make_fail(input logic [1:0] st, input logic [7:0] ty,
                                          input logic [30:0] off);
        t_result r;
        r             = '0;
        r.status      = st;
        r.elem_type   = ty;
        r.elem_offset = off;
        return r;
    endfunction

    function automatic logic known_type(input logic [7:0] t);
        logic k;
        case (t) inside
            bsep_pkg::T_FP64, bsep_pkg::T_STRING, bsep_pkg::T_DOCUMENT,
            bsep_pkg::T_ARRAY, bsep_pkg::T_BINARY, bsep_pkg::T_UNDEFINED,
            bsep_pkg::T_BOOLEAN, bsep_pkg::T_NULL, bsep_pkg::T_INT32,
            bsep_pkg::T_INT64: k = 1'b1;
            default:           k = 1'b0;
        endcase
        return k;
    endfunction

    // handshakes: the input register doubles as the skid stage
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign proc_go     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;

    bsep_fixed_value u_fixed_value (
        .i_elem_type (r_cur_type),
        .i_value     (shifted),
        .o_fixed     (fixed)
    );

    // a first-flagged byte restarts the walk at offset 0
    assign cur_phase = r_in_first ? bsep_pkg::PH_HEADER : r_phase;
    assign cur_pos   = r_in_first ? 31'd0 : r_position;
    assign cur_total = r_in_first ? 32'd0 : r_doc_total;
    assign pos_past  = ({1'b0, cur_pos} >= cur_total);

    // header byte lands in its little-endian lane
    always_comb begin
        hdr_total = cur_total;
        hdr_total[{cur_pos[1:0], 3'b000} +: 8] = r_in_byte;
    end

    // payload bytes shift in from the top
    assign shifted   = {r_in_byte, r_value[63:8]};
    assign left_done = (r_bytes_left == 32'd1);

    // fixed payload size, or the length word for variable types
    always_comb begin
        case (r_cur_type) inside
            bsep_pkg::T_FP64, bsep_pkg::T_INT64: fixed_n = 4'd8;
            bsep_pkg::T_INT32:                   fixed_n = 4'd4;
            default:                             fixed_n = (r_cur_type == bsep_pkg::T_BOOLEAN)
                                                           ? 4'd1 : 4'd4;
        endcase
    end
    assign ds_end = {3'd0, cur_pos} + 34'd1 + {30'd0, fixed_n};

    // length word checks and body size
    assign lw = shifted[63:32];
    always_comb begin
        case (r_cur_type)
            bsep_pkg::T_STRING: body = {1'b0, lw};
            bsep_pkg::T_BINARY: body = {1'b0, lw} + 33'd1;
            default:            body = {1'b0, lw} - 33'd4;
        endcase
    end
    assign body_end = {3'd0, r_data_start} + 34'd4 + {1'b0, body};
    assign lw_bad   = lw[31]
                   || ((r_cur_type == bsep_pkg::T_STRING) && (lw == 32'd0))
                   || (((r_cur_type == bsep_pkg::T_DOCUMENT)
                        || (r_cur_type == bsep_pkg::T_ARRAY)) && (lw < 32'd5))
                   || (body_end > {2'd0, r_doc_total});

    // one byte of the walk
    always_comb begin
        n_phase       = r_phase;
        n_position    = r_position;
        n_doc_total   = r_doc_total;
        n_cur_type    = r_cur_type;
        n_elem_start  = r_elem_start;
        n_data_start  = r_data_start;
        n_length_word = r_length_word;
        n_bytes_left  = r_bytes_left;
        n_value       = r_value;
        res_valid     = 1'b0;
        res           = '0;
        acc           = 1'b0;
        acc_dlen      = '0;
        acc_raw       = '0;
        acc_truthy    = 1'b0;

        if (r_in_first) begin
            n_phase     = bsep_pkg::PH_HEADER;
            n_position  = 31'd0;
            n_doc_total = 32'd0;
            n_cur_type  = 8'd0;
        end

        if (r_in_first && (r_buffer_length < 31'd4)) begin
            // buffer cannot even hold the length word
            n_phase   = bsep_pkg::PH_IDLE;
            res_valid = 1'b1;
            res       = make_fail(bsep_pkg::ST_FAIL, 8'd0, 31'd0);
        end else if (cur_phase != bsep_pkg::PH_IDLE) begin
            n_position = cur_pos + 31'd1;
            unique case (cur_phase)
                bsep_pkg::PH_HEADER: begin
                    n_doc_total = hdr_total;
                    if (cur_pos >= 31'd3) begin
                        if (hdr_total[31] || (hdr_total < 32'd4)
                            || (hdr_total > {1'b0, r_buffer_length})) begin
                            n_phase   = bsep_pkg::PH_IDLE;
                            res_valid = 1'b1;
                            res       = make_fail(bsep_pkg::ST_FAIL, 8'd0, 31'd0);
                        end else begin
                            n_phase = bsep_pkg::PH_TYPE;
                        end
                    end
                end
                bsep_pkg::PH_TYPE: begin
                    if (pos_past) begin
                        n_phase   = bsep_pkg::PH_IDLE;
                        res_valid = 1'b1;
                        res       = make_fail(bsep_pkg::ST_FAIL, 8'd0, cur_pos);
                    end else if (r_in_byte == 8'd0) begin
                        // terminator of the document
                        n_phase   = bsep_pkg::PH_IDLE;
                        res_valid = 1'b1;
                        res       = make_fail(bsep_pkg::ST_END, 8'd0, cur_pos);
                    end else begin
                        n_cur_type   = r_in_byte;
                        n_elem_start = cur_pos;
                        if (!known_type(r_in_byte)) begin
                            n_phase   = bsep_pkg::PH_IDLE;
                            res_valid = 1'b1;
                            res       = make_fail(bsep_pkg::ST_FAIL, r_in_byte, cur_pos);
                        end else begin
                            n_phase = bsep_pkg::PH_NAME;
                        end
                    end
                end
                bsep_pkg::PH_NAME: begin
                    if (pos_past) begin
                        n_phase   = bsep_pkg::PH_IDLE;
                        res_valid = 1'b1;
                        res       = make_fail(bsep_pkg::ST_FAIL, r_cur_type, r_elem_start);
                    end else if (r_in_byte == 8'd0) begin
                        n_data_start = cur_pos + 31'd1;
                        n_value      = 64'd0;
                        if ((r_cur_type == bsep_pkg::T_UNDEFINED)
                            || (r_cur_type == bsep_pkg::T_NULL)) begin
                            acc = 1'b1;
                        end else if (ds_end > {2'd0, cur_total}) begin
                            n_phase   = bsep_pkg::PH_IDLE;
                            res_valid = 1'b1;
                            res       = make_fail(bsep_pkg::ST_FAIL, r_cur_type, r_elem_start);
                        end else begin
                            n_bytes_left = {28'd0, fixed_n};
                            n_phase      = ((r_cur_type == bsep_pkg::T_FP64)
                                         || (r_cur_type == bsep_pkg::T_INT64)
                                         || (r_cur_type == bsep_pkg::T_INT32)
                                         || (r_cur_type == bsep_pkg::T_BOOLEAN))
                                         ? bsep_pkg::PH_FIXED : bsep_pkg::PH_LENWORD;
                        end
                    end
                end
                bsep_pkg::PH_FIXED: begin
                    n_value      = shifted;
                    n_bytes_left = r_bytes_left - 32'd1;
                    if (left_done) begin
                        acc        = 1'b1;
                        acc_dlen   = {27'd0, fixed.data_length};
                        acc_raw    = fixed.raw_value;
                        acc_truthy = fixed.is_truthy;
                    end
                end
                bsep_pkg::PH_LENWORD: begin
                    n_value      = shifted;
                    n_bytes_left = r_bytes_left - 32'd1;
                    if (left_done) begin
                        n_length_word = lw;
                        if (lw_bad) begin
                            n_phase   = bsep_pkg::PH_IDLE;
                            res_valid = 1'b1;
                            res       = make_fail(bsep_pkg::ST_FAIL, r_cur_type, r_elem_start);
                        end else begin
                            n_bytes_left = body[31:0];
                            n_phase      = bsep_pkg::PH_BODY;
                        end
                    end
                end
                bsep_pkg::PH_BODY: begin
                    n_bytes_left = r_bytes_left - 32'd1;
                    if (left_done) begin
                        acc_raw = {32'd0, r_length_word};
                        if (r_cur_type == bsep_pkg::T_BINARY) begin
                            acc        = 1'b1;
                            acc_dlen   = r_length_word[30:0] + 31'd5;
                            acc_truthy = 1'b1;
                        end else if (r_in_byte != 8'd0) begin
                            // missing terminator
                            n_phase   = bsep_pkg::PH_IDLE;
                            res_valid = 1'b1;
                            res       = make_fail(bsep_pkg::ST_FAIL, r_cur_type, r_elem_start);
                        end else if (r_cur_type == bsep_pkg::T_STRING) begin
                            acc        = 1'b1;
                            acc_dlen   = r_length_word[30:0] + 31'd4;
                            acc_truthy = (r_length_word > 32'd1);
                        end else begin
                            acc        = 1'b1;
                            acc_dlen   = r_length_word[30:0];
                            acc_truthy = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = bsep_pkg::PH_IDLE;
                end
            endcase
        end

        // element accepted: report it and go look for the next type byte
        if (acc) begin
            n_phase         = bsep_pkg::PH_TYPE;
            res_valid       = 1'b1;
            res.status      = bsep_pkg::ST_ELEM;
            res.elem_type   = r_cur_type;
            res.elem_offset = r_elem_start;
            res.name_length = n_data_start - r_elem_start - 31'd2;
            res.data_offset = n_data_start;
            res.data_length = acc_dlen;
            res.raw_value   = acc_raw;
            res.is_truthy   = acc_truthy;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= 31'd0;
        end else if (i_cfg_valid) begin
            r_buffer_length <= i_buffer_length;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= bsep_pkg::PH_IDLE;
            r_position    <= 31'd0;
            r_doc_total   <= 32'd0;
            r_cur_type    <= 8'd0;
            r_elem_start  <= 31'd0;
            r_data_start  <= 31'd0;
            r_length_word <= 32'd0;
            r_bytes_left  <= 32'd0;
            r_value       <= 64'd0;
        end else if (proc_go) begin
            r_phase       <= n_phase;
            r_position    <= n_position;
            r_doc_total   <= n_doc_total;
            r_cur_type    <= n_cur_type;
            r_elem_start  <= n_elem_start;
            r_data_start  <= n_data_start;
            r_length_word <= n_length_word;
            r_bytes_left  <= n_bytes_left;
            r_value       <= n_value;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_go && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_elem_type   = r_out.elem_type;
    assign o_elem_offset = r_out.elem_offset;
    assign o_name_length = r_out.name_length;
    assign o_data_offset = r_out.data_offset;
    assign o_data_length = r_out.data_length;
    assign o_raw_value   = r_out.raw_value;
    assign o_is_truthy   = r_out.is_truthy;

endmodule

@@ rtl/bsep_fixed_value.sv @@
// ----------------------------------------------------------------------------
// bsep_fixed_value
// decodes a fixed-size payload into raw value, truthiness and length
// ----------------------------------------------------------------------------
module bsep_fixed_value (
    input  logic [7:0]           i_elem_type,
    input  logic [63:0]          i_value,
    output bsep_pkg::t_fixed_val o_fixed
);

    logic [62:0] mag;
    logic [31:0] upper;

    assign mag   = i_value[62:0];
    assign upper = i_value[63:32];

    always_comb begin
        unique case (i_elem_type)
            bsep_pkg::T_FP64: begin
                // nan and signed zero are false
                o_fixed.raw_value   = i_value;
                o_fixed.is_truthy   = (mag != 63'd0) && (mag <= 63'h7FF0_0000_0000_0000);
                o_fixed.data_length = 4'd8;
            end
            bsep_pkg::T_INT64: begin
                o_fixed.raw_value   = i_value;
                o_fixed.is_truthy   = (i_value != 64'd0);
                o_fixed.data_length = 4'd8;
            end
            bsep_pkg::T_INT32: begin
                o_fixed.raw_value   = {{32{upper[31]}}, upper};
                o_fixed.is_truthy   = (upper != 32'd0);
                o_fixed.data_length = 4'd4;
            end
            default: begin
                // boolean: the single byte sits at the top
                o_fixed.raw_value   = {56'd0, i_value[63:56]};
                o_fixed.is_truthy   = (i_value[63:56] != 8'd0);
                o_fixed.data_length = 4'd1;
            end
        endcase
    end

endmodule

@@ rtl/bsep_checker.sv @@
// ----------------------------------------------------------------------------
// bsep_checker
// port-level checks of the bson element stream parser results
// ----------------------------------------------------------------------------
`include "bson_element_stream_parser_defines.svh"

module bsep_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic [30:0]        o_elem_offset,
    input logic [30:0]        o_name_length,
    input logic [30:0]        o_data_offset,
    input logic [30:0]        o_data_length,
    input logic signed [63:0] o_raw_value,
    input logic               o_is_truthy
);

    // only the three defined status codes appear
    `BSEP_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, (o_status == bsep_pkg::ST_ELEM) || (o_status == bsep_pkg::ST_END) || (o_status == bsep_pkg::ST_FAIL))

    // end and failure beats carry no element detail
    `BSEP_ASSERT_IMP(a_term_clean, i_clk, i_rst_n, o_out_valid && (o_status != bsep_pkg::ST_ELEM), (o_name_length == 31'd0) && (o_data_offset == 31'd0) && (o_data_length == 31'd0) && (o_raw_value == 64'sd0) && !o_is_truthy)

    // payload follows type byte, name and its nul
    `BSEP_ASSERT_IMP(a_elem_layout, i_clk, i_rst_n, o_out_valid && (o_status == bsep_pkg::ST_ELEM), o_data_offset == (o_elem_offset + o_name_length + 31'd2))

    // a stalled result beat holds
    `BSEP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_elem_offset) && $stable(o_raw_value))

endmodule

bind bson_element_stream_parser bsep_checker u_bsep_checker (.*);

@@ test/bson_element_stream_parser_checker.sv @@
// ----------------------------------------------------------------------------
// bson element stream parser checker
// watches the config, byte and result channels, walks each accepted byte
// through its own parser state and compares every result beat with the
// oldest expected element result
// ----------------------------------------------------------------------------
module bson_element_stream_parser_checker
    import bsep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [30:0] i_buffer_length,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [7:0]  i_elem_type,
    input  logic [30:0] i_elem_offset,
    input  logic [30:0] i_name_length,
    input  logic [30:0] i_data_offset,
    input  logic [30:0] i_data_length,
    input  logic [63:0] i_raw_value,
    input  logic        i_is_truthy,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  elem_type;
        logic [30:0] elem_offset;
        logic [30:0] name_length;
        logic [30:0] data_offset;
        logic [30:0] data_length;
        logic [63:0] raw_value;
        logic        is_truthy;
    } elem_result_t;

    // parser state
    logic [3:0]  ph         = PH_IDLE;
    logic [30:0] pos_cnt    = '0;
    logic [31:0] total_len  = '0;
    logic [7:0]  el_type    = '0;
    logic [30:0] el_start   = '0;
    logic [30:0] dat_start  = '0;
    logic [31:0] len_word   = '0;
    logic [31:0] left_cnt   = '0;
    logic [63:0] shift_val  = '0;
    logic [30:0] buf_len    = '0;

    elem_result_t elem_result_q [$];
    int           mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic elem_result_t make_result(logic [1:0] st, logic [7:0] ty,
                                                 logic [30:0] eoff, nlen, doff, dlen,
                                                 logic [63:0] raw, logic truthy);
        elem_result_t r;
        r.status      = st;
        r.elem_type   = ty;
        r.elem_offset = eoff;
        r.name_length = nlen;
        r.data_offset = doff;
        r.data_length = dlen;
        r.raw_value   = raw;
        r.is_truthy   = truthy;
        return r;
    endfunction

    function automatic elem_result_t fail_result(logic [7:0] ty, logic [30:0] eoff);
        ph = PH_IDLE;
        return make_result(ST_FAIL, ty, eoff, '0, '0, '0, '0, 1'b0);
    endfunction

    function automatic elem_result_t accept_result(logic [63:0] dlen, logic [63:0] raw,
                                                   logic truthy);
        ph = PH_TYPE;
        // name length: data start minus type byte and name terminator
        return make_result(ST_ELEM, el_type, el_start, dat_start - el_start - 31'd2,
                           dat_start, dlen[30:0], raw, truthy);
    endfunction

    // advance the parser by one byte; returns 1 when the byte yields a result
    function automatic bit walk_byte(input logic [7:0] b, input logic f,
                                     output elem_result_t r);
        logic [30:0] p;
        logic [63:0] ds;
        logic [63:0] body;
        logic [63:0] mag;
        logic [63:0] w;
        logic [31:0] lw;
        int          nfix;
        bit          bad;
        r = '0;
        if (f) begin
            ph        = PH_HEADER;
            pos_cnt   = '0;
            total_len = '0;
            el_type   = '0;
            if (buf_len < 31'd4) begin
                r = fail_result(8'h00, 31'd0);
                return 1'b1;
            end
        end else if (ph == PH_IDLE) begin
            return 1'b0;
        end
        p       = pos_cnt;
        pos_cnt = p + 31'd1;

        case (ph)
            PH_HEADER: begin
                total_len = total_len | (32'(b) << (8 * p[1:0]));
                if (p >= 31'd3) begin
                    if (total_len[31] || total_len < 32'd4 || total_len > {1'b0, buf_len}) begin
                        r = fail_result(8'h00, 31'd0);
                        return 1'b1;
                    end
                    ph = PH_TYPE;
                end
                return 1'b0;
            end
            PH_TYPE: begin
                if ({1'b0, p} >= total_len) begin
                    r = fail_result(8'h00, p);
                    return 1'b1;
                end
                if (b == 8'h00) begin
                    ph = PH_IDLE;
                    r = make_result(ST_END, 8'h00, p, '0, '0, '0, '0, 1'b0);
                    return 1'b1;
                end
                el_type  = b;
                el_start = p;
                case (b)
                    T_FP64, T_STRING, T_DOCUMENT, T_ARRAY, T_BINARY, T_UNDEFINED,
                    T_BOOLEAN, T_NULL, T_INT32, T_INT64: begin
                        ph = PH_NAME;
                        return 1'b0;
                    end
                    default: begin
                        r = fail_result(b, p);
                        return 1'b1;
                    end
                endcase
            end
            PH_NAME: begin
                if ({1'b0, p} >= total_len) begin
                    r = fail_result(el_type, el_start);
                    return 1'b1;
                end
                if (b != 8'h00) return 1'b0;
                ds        = 64'(p) + 64'd1;
                dat_start = ds[30:0];
                shift_val = '0;
                if (el_type == T_UNDEFINED || el_type == T_NULL) begin
                    r = accept_result(64'd0, 64'd0, 1'b0);
                    return 1'b1;
                end
                case (el_type)
                    T_FP64, T_INT64: nfix = 8;
                    T_INT32:         nfix = 4;
                    T_BOOLEAN:       nfix = 1;
                    default:         nfix = 0;
                endcase
                // fixed payload or length word must fit inside the total
                if (ds + ((nfix != 0) ? 64'(nfix) : 64'd4) > 64'(total_len)) begin
                    r = fail_result(el_type, el_start);
                    return 1'b1;
                end
                left_cnt = (nfix != 0) ? 32'(nfix) : 32'd4;
                ph       = (nfix != 0) ? PH_FIXED : PH_LENWORD;
                return 1'b0;
            end
            PH_FIXED: begin
                shift_val = {b, shift_val[63:8]};
                left_cnt  = left_cnt - 32'd1;
                if (left_cnt != 0) return 1'b0;
                case (el_type)
                    T_FP64: begin
                        mag = {1'b0, shift_val[62:0]};
                        r = accept_result(64'd8, shift_val,
                                          mag != 0 && mag <= 64'h7FF0_0000_0000_0000);
                    end
                    T_INT64: r = accept_result(64'd8, shift_val, shift_val != 0);
                    T_INT32: begin
                        w = {{32{shift_val[63]}}, shift_val[63:32]};
                        r = accept_result(64'd4, w, w != 0);
                    end
                    default: begin
                        w = {56'd0, shift_val[63:56]};
                        r = accept_result(64'd1, w, w != 0);
                    end
                endcase
                return 1'b1;
            end
            PH_LENWORD: begin
                shift_val = {b, shift_val[63:8]};
                left_cnt  = left_cnt - 32'd1;
                if (left_cnt != 0) return 1'b0;
                lw       = shift_val[63:32];
                len_word = lw;
                bad      = lw[31];
                case (el_type)
                    T_STRING: begin
                        bad  = bad || lw < 32'd1;
                        body = 64'(lw);
                    end
                    T_BINARY: body = 64'(lw) + 64'd1;
                    default: begin
                        bad  = bad || lw < 32'd5;
                        body = 64'(lw) - 64'd4;
                    end
                endcase
                if (bad || 64'(dat_start) + 64'd4 + body > 64'(total_len)) begin
                    r = fail_result(el_type, el_start);
                    return 1'b1;
                end
                left_cnt = body[31:0];
                ph       = PH_BODY;
                return 1'b0;
            end
            PH_BODY: begin
                left_cnt = left_cnt - 32'd1;
                if (left_cnt != 0) return 1'b0;
                if (el_type == T_BINARY)
                    r = accept_result(64'(len_word) + 64'd5, 64'(len_word), 1'b1);
                else if (b != 8'h00)
                    r = fail_result(el_type, el_start);
                else if (el_type == T_STRING)
                    r = accept_result(64'(len_word) + 64'd4, 64'(len_word), len_word > 32'd1);
                else
                    r = accept_result(64'(len_word), 64'(len_word), 1'b1);
                return 1'b1;
            end
            default: begin
                ph = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        elem_result_t got;
        elem_result_t want;
        elem_result_t nxt;
        if (!i_rst_n) begin
            ph        = PH_IDLE;
            pos_cnt   = '0;
            total_len = '0;
            el_type   = '0;
            el_start  = '0;
            dat_start = '0;
            len_word  = '0;
            left_cnt  = '0;
            shift_val = '0;
            buf_len   = '0;
            elem_result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                buf_len = i_buffer_length;
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_elem_type, i_elem_offset, i_name_length, i_data_offset,
                       i_data_length, i_raw_value, i_is_truthy};
                if (elem_result_q.size() == 0) begin
                    $error("unexpected result beat: status %0d offset %0d",
                           got.status, got.elem_offset);
                    mismatches++;
                end else begin
                    want = elem_result_q.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("elem_type", 64'(want.elem_type), 64'(got.elem_type));
                    check_field("elem_offset", 64'(want.elem_offset), 64'(got.elem_offset));
                    check_field("name_length", 64'(want.name_length), 64'(got.name_length));
                    check_field("data_offset", 64'(want.data_offset), 64'(got.data_offset));
                    check_field("data_length", 64'(want.data_length), 64'(got.data_length));
                    check_field("raw_value", want.raw_value, got.raw_value);
                    check_field("is_truthy", 64'(want.is_truthy), 64'(got.is_truthy));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (walk_byte(i_data_byte, i_first, nxt))
                    elem_result_q.push_back(nxt);
            end
        end
        o_pending    <= elem_result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ test/bson_element_stream_parser_tb.sv @@
// ----------------------------------------------------------------------------
// bson element stream parser testbench
// feeds byte streams of directed and random bson documents, well formed and
// broken, under several buffer lengths with random idle bursts and one long
// result hold-off; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module bson_element_stream_parser_tb;
    import bsep_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 400;    // cycles of the one long result hold-off
    localparam logic [30:0] MAX_LEN       = 31'h7FFF_FFFF;
    localparam logic [7:0]  T_UNUSED      = 8'h07;  // type code with no meaning
    localparam logic [7:0]  KNOWN_TYPES [10] = '{T_FP64, T_STRING, T_DOCUMENT, T_ARRAY,
                                                 T_BINARY, T_UNDEFINED, T_BOOLEAN, T_NULL,
                                                 T_INT32, T_INT64};

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_valid     = 1'b0;
    logic               o_cfg_ready;
    logic [30:0]        i_buffer_length = '0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_data_byte     = '0;
    logic               i_first         = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall     = 1'b0;
    logic [1:0]         o_status;
    logic [7:0]         o_elem_type;
    logic [30:0]        o_elem_offset;
    logic [30:0]        o_name_length;
    logic [30:0]        o_data_offset;
    logic [30:0]        o_data_length;
    logic signed [63:0] o_raw_value;
    logic               o_is_truthy;

    int fail_count;
    int pending;
    int cycle_cnt       = 0;
    int stall_left      = 0;
    bit long_hold_taken = 1'b0;
    bit long_hold_go    = 1'b0;
    bit quiet           = 1'b0;     // no idling on either side once set

    // byte beats still to send: bit 8 is the first flag
    logic [8:0] beat_q [$];
    // body of the document being built, without header and terminator
    logic [7:0] body_q [$];

    bson_element_stream_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_buffer_length (i_buffer_length),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_first         (i_first),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_elem_type     (o_elem_type),
        .o_elem_offset   (o_elem_offset),
        .o_name_length   (o_name_length),
        .o_data_offset   (o_data_offset),
        .o_data_length   (o_data_length),
        .o_raw_value     (o_raw_value),
        .o_is_truthy     (o_is_truthy)
    );

    bson_element_stream_parser_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_buffer_length (i_buffer_length),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_first         (i_first),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_elem_type     (o_elem_type),
        .i_elem_offset   (o_elem_offset),
        .i_name_length   (o_name_length),
        .i_data_offset   (o_data_offset),
        .i_data_length   (o_data_length),
        .i_raw_value     (o_raw_value),
        .i_is_truthy     (o_is_truthy),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off so the block
    // backs up and stalls its byte input while the sender keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                if (long_hold_go && !long_hold_taken) begin
                    long_hold_taken = 1'b1;
                    stall_left = LONG_HOLD;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 16);
                end
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // document building
    // ------------------------------------------------------------------------

    task automatic add_raw(input logic [7:0] b, input logic f);
        beat_q.push_back({f, b});
    endtask

    // natural total length: header, body and end byte
    function automatic logic [31:0] doc_size();
        return 32'(body_q.size() + 5);
    endfunction

    // header with the given total, the body built so far, optional end byte
    task automatic put_doc(input logic [31:0] total, input bit add_end);
        for (int i = 0; i < 4; i++)
            add_raw(total[8*i +: 8], i == 0);
        foreach (body_q[i])
            add_raw(body_q[i], 1'b0);
        if (add_end)
            add_raw(8'h00, 1'b0);
        body_q.delete();
    endtask

    // one element: type byte, nlen name bytes, NUL, then the payload; bodies
    // of length-word types are only emitted for small length words
    task automatic add_element(input logic [7:0] t, input int nlen, input logic [63:0] val,
                               input logic [31:0] lw, input bit good_end);
        int nfix;
        int n;
        body_q.push_back(t);
        repeat (nlen) body_q.push_back(8'($urandom_range(1, 255)));
        body_q.push_back(8'h00);
        case (t)
            T_FP64, T_INT64: nfix = 8;
            T_INT32:         nfix = 4;
            T_BOOLEAN:       nfix = 1;
            default:         nfix = 0;
        endcase
        for (int i = 0; i < nfix; i++)
            body_q.push_back(val[8*i +: 8]);
        if (t == T_STRING || t == T_DOCUMENT || t == T_ARRAY || t == T_BINARY) begin
            for (int i = 0; i < 4; i++)
                body_q.push_back(lw[8*i +: 8]);
            if (lw <= 32'd32) begin
                n = (t == T_STRING) ? int'(lw) : (t == T_BINARY) ? int'(lw) + 1 : int'(lw) - 4;
                for (int i = 0; i < n; i++) begin
                    if (i < n - 1 || t == T_BINARY)
                        body_q.push_back(8'($urandom));
                    else
                        body_q.push_back(good_end ? 8'h00 : 8'($urandom_range(1, 255)));
                end
            end
        end
    endtask

    task automatic add_random_element();
        logic [7:0]  t;
        logic [63:0] v;
        logic [31:0] lw;
        t = ($urandom_range(0, 11) == 0) ? 8'($urandom) : KNOWN_TYPES[$urandom_range(0, 9)];
        case ($urandom_range(0, 9))
            0:       v = 64'd0;
            1:       v = 64'h8000_0000_0000_0000;   // negative zero
            2:       v = 64'h7FF0_0000_0000_0000;   // infinity
            3:       v = 64'h7FF0_0000_0000_0001;   // nan
            4:       v = 64'hFFFF_FFFF_0000_0000;
            5:       v = 64'd1;
            default: v = {$urandom, $urandom};
        endcase
        case (t)
            T_STRING: lw = $urandom_range(1, 8);
            T_BINARY: lw = $urandom_range(0, 6);
            default:  lw = $urandom_range(5, 10);
        endcase
        // occasionally a bad or oversized length word
        if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 4))
                0:       lw = 32'd0;
                1:       lw = 32'd4;
                2:       lw = 32'h8000_0000;
                3:       lw = 32'h7FFF_FFF0;
                default: lw = $urandom;
            endcase
        end
        add_element(t, $urandom_range(0, 3), v, lw, $urandom_range(0, 19) != 0);
    endtask

    // mostly well formed documents, the rest broken in one way or another
    task automatic add_random_doc();
        logic [31:0] total;
        int          mode;
        repeat ($urandom_range(0, 4)) add_random_element();
        total = doc_size();
        mode  = $urandom_range(0, 24);
        case (mode)
            0: total = total - 32'($urandom_range(1, 6));      // total too short
            1: total = total + 32'($urandom_range(1, 4));      // total too long
            2: if (body_q.size() != 0)
                   body_q[$urandom_range(0, body_q.size() - 1)] ^= 8'($urandom_range(1, 255));
            3: total = $urandom;
            4: if (body_q.size() != 0)                         // cut short, next doc restarts
                   repeat ($urandom_range(1, body_q.size())) void'(body_q.pop_back());
            default: ;
        endcase
        put_doc(total, mode != 4 && mode != 5);
        if (mode == 6)                                          // noise while idle
            repeat ($urandom_range(1, 4)) add_raw(8'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // channel driving
    // ------------------------------------------------------------------------

    task automatic write_buffer_length(input logic [30:0] v);
        i_cfg_valid     <= 1'b1;
        i_buffer_length <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // send every queued beat, with random idle bursts between beats
    task automatic drain_beats();
        logic [8:0] bt;
        while (beat_q.size() != 0) begin
            bt = beat_q.pop_front();
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_first     <= bt[8];
            i_data_byte <= bt[7:0];
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
    endtask

    // wait for every expected result, then let the pipeline run dry
    task automatic settle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [30:0] len);
        write_buffer_length(len);
        drain_beats();
        settle();
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial begin
        logic [30:0] len;
        int          target;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // buffer length still at its reset value: small buffer fails at once
        add_element(T_INT32, 1, 64'd1, '0, 1'b1);
        put_doc(doc_size(), 1'b1);
        drain_beats();
        settle();

        add_element(T_INT32, 1, 64'd1, '0, 1'b1);
        put_doc(doc_size(), 1'b1);
        run_phase(31'd3);

        // header only document, then the type byte lands on the total
        put_doc(32'd4, 1'b1);
        // total above the buffer length
        put_doc(32'd5, 1'b1);
        run_phase(31'd4);

        // every type, well formed
        add_element(T_FP64, 2, 64'h3FF0_0000_0000_0000, '0, 1'b1);
        add_element(T_STRING, 1, '0, 32'd4, 1'b1);
        add_element(T_DOCUMENT, 0, '0, 32'd5, 1'b1);
        add_element(T_ARRAY, 3, '0, 32'd7, 1'b1);
        add_element(T_BINARY, 1, '0, 32'd0, 1'b1);
        add_element(T_UNDEFINED, 1, '0, '0, 1'b1);
        add_element(T_BOOLEAN, 1, 64'd1, '0, 1'b1);
        add_element(T_NULL, 0, '0, '0, 1'b1);
        add_element(T_INT32, 1, 64'hFFFF_FFFB, '0, 1'b1);
        add_element(T_INT64, 1, 64'd0, '0, 1'b1);
        put_doc(doc_size(), 1'b1);
        // falsy and odd fp64 values, empty string
        add_element(T_FP64, 1, 64'h8000_0000_0000_0000, '0, 1'b1);
        add_element(T_FP64, 1, 64'h7FF8_0000_0000_0000, '0, 1'b1);
        add_element(T_FP64, 1, 64'hFFF0_0000_0000_0000, '0, 1'b1);
        add_element(T_STRING, 1, '0, 32'd1, 1'b1);
        add_element(T_BOOLEAN, 1, 64'd0, '0, 1'b1);
        add_element(T_INT32, 1, 64'hFFFF_FFFF_0000_0000, '0, 1'b1);
        put_doc(doc_size(), 1'b1);
        // negative total and total below four
        put_doc(32'hFFFF_FFFF, 1'b0);
        put_doc(32'd3, 1'b0);
        // empty document, then a type byte at the total
        put_doc(32'd5, 1'b1);
        put_doc(32'd4, 1'b1);
        // unknown type code
        add_element(T_UNUSED, 1, '0, '0, 1'b1);
        put_doc(doc_size(), 1'b1);
        // name runs past the total
        add_element(T_INT32, 3, '0, '0, 1'b1);
        put_doc(32'd6, 1'b1);
        // fixed payload would cross the total
        add_element(T_INT64, 1, {$urandom, $urandom}, '0, 1'b1);
        put_doc(doc_size() - 32'd2, 1'b1);
        // length word would cross the total
        add_element(T_STRING, 0, '0, 32'd2, 1'b1);
        put_doc(32'd9, 1'b1);
        // string body would cross the total
        add_element(T_STRING, 0, '0, 32'd6, 1'b1);
        put_doc(32'd13, 1'b1);
        // bad length words
        add_element(T_STRING, 0, '0, 32'd0, 1'b1);
        put_doc(doc_size(), 1'b1);
        add_element(T_DOCUMENT, 0, '0, 32'd4, 1'b1);
        put_doc(doc_size(), 1'b1);
        add_element(T_ARRAY, 0, '0, 32'h8000_0000, 1'b1);
        put_doc(doc_size(), 1'b1);
        add_element(T_BINARY, 0, '0, 32'h7FFF_FFF0, 1'b1);
        put_doc(doc_size(), 1'b1);
        // missing terminators
        add_element(T_STRING, 1, '0, 32'd3, 1'b0);
        put_doc(doc_size(), 1'b1);
        add_element(T_DOCUMENT, 1, '0, 32'd6, 1'b0);
        put_doc(doc_size(), 1'b1);
        // restart in the middle of a document, then noise while idle
        add_element(T_INT64, 1, {$urandom, $urandom}, '0, 1'b1);
        repeat (3) void'(body_q.pop_back());
        put_doc(32'd20, 1'b0);
        add_element(T_BOOLEAN, 0, 64'd1, '0, 1'b1);
        put_doc(doc_size(), 1'b1);
        add_raw(8'hFF, 1'b0);
        add_raw(8'h00, 1'b0);
        run_phase(MAX_LEN);

        // random documents under a spread of buffer lengths
        for (int ph_i = 0; ph_i < 8; ph_i++) begin
            case (ph_i)
                0:       len = MAX_LEN;
                1:       len = 31'($urandom_range(30, 90));
                2:       len = MAX_LEN;
                3:       len = 31'd4;
                4:       len = 31'($urandom);
                5:       len = 31'($urandom_range(16, 40));
                6:       len = MAX_LEN;
                default: len = 31'd60;
            endcase
            if (ph_i == 2)
                long_hold_go <= 1'b1;
            if (ph_i == 7)
                quiet <= 1'b1;
            target = (ph_i == 3) ? 60 : 140;
            while (beat_q.size() < target) add_random_doc();
            run_phase(len);
        end

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bsep_pkg.sv
rtl/bsep_fixed_value.sv
rtl/bson_element_stream_parser.sv
rtl/bsep_checker.sv
test/bson_element_stream_parser_checker.sv
test/bson_element_stream_parser_tb.sv
